// ===== hw/rtl/srn_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the row normalizer.
package srn_pkg;

    localparam int ROW_W     = 10;
    localparam int MAX_ROWS  = 1 << ROW_W;
    localparam int COL_W     = 10;
    localparam int VALUE_W   = 32;
    localparam int SUM_W     = VALUE_W + 8;
    localparam int FRAC_BITS = 24;
    localparam int NORM_W    = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(FRAC_BITS);
    localparam int CFG_W     = 11;
    localparam int LIMIT_W   = ROW_W + 1;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ACC   = 2'd0,
        OP_NORM  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ZERO,
        EMIT_ONE,
        EMIT_QUO
    } t_emit;

    typedef struct packed {
        logic  load;      // latch item, read row sum
        logic  acc_wr;    // write saturated sum back
        logic  div_init;
        logic  div_step;
        logic  clr_step;  // zero one row, advance pointer
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sum_zero;
        logic            val_ge_sum;
        logic            div_last;
        logic            clr_last;
        logic            clr_empty;
    } t_stat;

endpackage

// ===== hw/rtl/srn_datapath.sv =====
// Row-sum memory, saturating accumulator, restoring divider and result register.
module srn_datapath import srn_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ROW_W-1:0]    i_row_index,
    input  logic [COL_W-1:0]    i_column_index,
    input  logic [VALUE_W-1:0]  i_entry_value,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data,
    output logic                o_result_valid,
    output logic [ROW_W-1:0]    o_out_row,
    output logic [COL_W-1:0]    o_out_column,
    output logic [NORM_W-1:0]   o_normalized_value,
    output logic                o_zero_sum
);

    logic [SUM_W-1:0]   r_mem [MAX_ROWS];
    logic [SUM_W-1:0]   r_rd;
    logic [OP_W-1:0]    r_op;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [VALUE_W-1:0] r_val;
    logic [CFG_W-1:0]   r_rows_in_use;
    logic [ROW_W-1:0]   r_ptr;
    logic [LIMIT_W-1:0] r_limit;
    logic [SUM_W-1:0]   r_rem;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_valid;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic [NORM_W-1:0]  r_norm;
    logic               r_zero;

    logic [SUM_W:0]     acc_sum;
    logic [SUM_W-1:0]   acc_sat;
    logic [SUM_W:0]     rem_sh;
    logic               rem_ge;
    logic [SUM_W-1:0]   n_rem;
    logic [LIMIT_W-1:0] cfg_limit;
    logic               mem_we;
    logic [ROW_W-1:0]   mem_wa;
    logic [SUM_W-1:0]   mem_wd;

    assign acc_sum = {1'b0, r_rd} + (SUM_W+1)'(r_val);
    assign acc_sat = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];

    // one restoring step: shift, compare, subtract
    assign rem_sh = {r_rem, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, r_rd});
    assign n_rem  = rem_ge ? SUM_W'(rem_sh - {1'b0, r_rd}) : rem_sh[SUM_W-1:0];

    assign cfg_limit = (r_rows_in_use > CFG_W'(MAX_ROWS)) ? LIMIT_W'(MAX_ROWS)
                                                           : LIMIT_W'(r_rows_in_use);

    assign mem_we = i_cmd.acc_wr | i_cmd.clr_step;
    assign mem_wa = i_cmd.acc_wr ? r_row : r_ptr;
    assign mem_wd = i_cmd.acc_wr ? acc_sat : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.load) begin
            r_rd <= r_mem[i_row_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_row <= i_row_index;
            r_col <= i_column_index;
            r_val <= i_entry_value;
        end
        if (i_cmd.div_init) begin
            r_rem <= SUM_W'(r_val);
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[FRAC_BITS-2:0], rem_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // config and clear sweep; reset loads a full sweep for the power-up clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_W'(MAX_ROWS);
            r_ptr         <= '0;
            r_limit       <= LIMIT_W'(MAX_ROWS);
        end else begin
            if (i_cfg_wr_en) begin
                r_rows_in_use <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_ptr   <= '0;
                r_limit <= cfg_limit;
            end else if (i_cmd.clr_step) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.emit != EMIT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EMIT_NONE) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
        end
        case (i_cmd.emit)
            EMIT_ZERO: begin
                r_norm <= '0;
                r_zero <= 1'b1;
            end
            EMIT_ONE: begin
                r_norm <= NORM_W'(1) << FRAC_BITS;
                r_zero <= 1'b0;
            end
            EMIT_QUO: begin
                r_norm <= {1'b0, r_quo};
                r_zero <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.op         = r_op;
    assign o_stat.sum_zero   = (r_rd == '0);
    assign o_stat.val_ge_sum = (SUM_W'(r_val) >= r_rd);
    assign o_stat.div_last   = (r_cnt == CNT_W'(FRAC_BITS - 1));
    assign o_stat.clr_last   = ((LIMIT_W'(r_ptr) + 1'b1) == r_limit);
    assign o_stat.clr_empty  = (r_limit == '0);

    assign o_result_valid     = r_valid;
    assign o_out_row          = r_out_row;
    assign o_out_column       = r_out_col;
    assign o_normalized_value = r_norm;
    assign o_zero_sum         = r_zero;

endmodule

// ===== hw/rtl/srn_ctrl.sv =====
// Sequencer for accumulate, normalize, clear and the power-up clear sweep.
module srn_ctrl import srn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT,
        S_CLR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT, S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
                case (i_stat.op)
                    OP_ACC: o_cmd.acc_wr = 1'b1;
                    OP_NORM: begin
                        if (i_stat.sum_zero) begin
                            o_cmd.emit = EMIT_ZERO;
                        end else if (i_stat.val_ge_sum) begin
                            o_cmd.emit = EMIT_ONE;
                        end else begin
                            o_cmd.div_init = 1'b1;
                            n_state        = S_DIV;
                        end
                    end
                    OP_CLEAR: begin
                        if (!i_stat.clr_empty) n_state = S_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = EMIT_QUO;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== hw/rtl/sparse_row_normalizer_top.sv =====
// Top level of the sparse matrix row normalizer.
// Sparse row normalizer. Items are taken at a clock edge with start high and
// busy low; one item is worked at a time. Operation 0 adds entry_value
// (unsigned Q8.24) to its row's Q16.24 sum, saturating at all ones, by a
// memory read, then a write-back. Operation 1 divides entry_value by the
// row sum and returns one result: without dividing when the sum is zero
// (zero_sum set, value 0) or not above the entry (value 1.0 = 0x1000000),
// otherwise from the restoring divider, which retires one quotient bit per
// cycle over 24 bits. Operation 2 zeroes rows 0 to rows_in_use-1 (at most
// 1024) one row per cycle, and no row if rows_in_use is zero. Operation 3
// is dropped. After reset, busy stays high for a pass that clears the
// row-sum memory. A result shows for exactly one cycle with o_result_valid;
// the receiver cannot stall it, and a new item may be taken while it shows.
// rows_in_use is written through i_cfg_wr_en/i_cfg_wr_data; the user must
// write it only while the block is idle; the block does not enforce this.
module sparse_row_normalizer_top import srn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [ROW_W-1:0]   i_row_index,
    input  logic [COL_W-1:0]   i_column_index,
    input  logic [VALUE_W-1:0] i_entry_value,
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    output logic               o_result_valid,
    output logic [ROW_W-1:0]   o_out_row,
    output logic [COL_W-1:0]   o_out_column,
    output logic [NORM_W-1:0]  o_normalized_value,
    output logic               o_zero_sum
);

    t_cmd  cmd;
    t_stat stat;

    srn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    srn_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_operation        (i_operation),
        .i_row_index        (i_row_index),
        .i_column_index     (i_column_index),
        .i_entry_value      (i_entry_value),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_result_valid     (o_result_valid),
        .o_out_row          (o_out_row),
        .o_out_column       (o_out_column),
        .o_normalized_value (o_normalized_value),
        .o_zero_sum         (o_zero_sum)
    );

endmodule

// ===== hw/rtl/srn_checker.sv =====
// Port-level assertions for the row normalizer, bound to its top level.
module srn_checker import srn_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input logic [NORM_W-1:0] o_normalized_value,
    input logic              o_zero_sum
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results on adjacent cycles");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without an item in work");

    a_zero_sum_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_zero_sum |-> o_normalized_value == '0)
        else $error("zero row sum with nonzero value");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_normalized_value <= (NORM_W'(1) << FRAC_BITS))
        else $error("normalized value above 1.0");

endmodule

bind sparse_row_normalizer_top srn_checker u_srn_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_result_valid     (o_result_valid),
    .o_normalized_value (o_normalized_value),
    .o_zero_sum         (o_zero_sum)
);
